// ----- src/playfair_digraph_cipher_defines.svh -----
// ----------------------------------------------------------------------------
// Playfair digraph cipher assertion macros
// Shared assertion forms for the cipher block, clocked on clk, idle in rst.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH

// same-cycle implication
`define PF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pf_pkg.sv -----
// ----------------------------------------------------------------------------
// Playfair cipher package
// Types, constants and key-square lookup functions for the cipher block.
// ----------------------------------------------------------------------------
package pf_pkg;

  localparam int SIDE      = 5;
  localparam int CODE_W    = 5;
  localparam int ROW_W     = SIDE * CODE_W;
  localparam int POS_W     = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [CODE_W-1:0] CODE_X = 5'd23;
  localparam logic [CODE_W-1:0] CODE_J = 5'd9;
  localparam logic [CODE_W-1:0] CODE_I = 5'd8;

  localparam logic [POS_W-1:0] POS_FIRST = 3'd0;
  localparam logic [POS_W-1:0] POS_LAST  = 3'(SIDE - 1);

  // alphabet without j, row-major
  localparam logic [ROW_W-1:0] ROW0_RST = 25'd4294688;
  localparam logic [ROW_W-1:0] ROW1_RST = 25'd10755269;
  localparam logic [ROW_W-1:0] ROW2_RST = 25'd16201099;
  localparam logic [ROW_W-1:0] ROW3_RST = 25'd21613104;
  localparam logic [ROW_W-1:0] ROW4_RST = 25'd27025109;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW0 = 3'd0,
    CFG_ROW1 = 3'd1,
    CFG_ROW2 = 3'd2,
    CFG_ROW3 = 3'd3,
    CFG_ROW4 = 3'd4,
    CFG_MODE = 3'd5
  } cfg_reg_t;

  typedef logic [SIDE-1:0][CODE_W-1:0] row_t;
  typedef row_t [SIDE-1:0]             square_t;

  typedef struct packed {
    logic [CODE_W-1:0] letter_code;
    logic              message_end;
  } letter_t;

  typedef struct packed {
    logic [CODE_W-1:0] out_letter;
    logic              second_of_pair;
    logic              end_of_output;
    logic              not_in_square;
  } result_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } loc_t;

  // first match in row-major order wins
  function automatic loc_t locate(square_t sq, logic [CODE_W-1:0] code);
    loc_t res;
    res = '0;
    for (int r = SIDE - 1; r >= 0; r--) begin
      for (int c = SIDE - 1; c >= 0; c--) begin
        if (sq[r][c] == code) begin
          res.found = 1'b1;
          res.row   = POS_W'(r);
          res.col   = POS_W'(c);
        end
      end
    end
    return res;
  endfunction

  // one step along a row or column, wrapping; dec selects the backward step
  function automatic logic [POS_W-1:0] step_pos(logic [POS_W-1:0] v, logic dec);
    logic [POS_W-1:0] res;
    if (dec) begin
      res = (v == POS_FIRST) ? POS_LAST : v - 3'd1;
    end else begin
      res = (v >= POS_LAST) ? POS_FIRST : v + 3'd1;
    end
    return res;
  endfunction

endpackage

// ----- src/playfair_digraph_cipher.sv -----
// ----------------------------------------------------------------------------
// Playfair digraph cipher
// Pairs a letter stream and maps each pair through a 5x5 key square.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------------------
//  letter   | in        | letter_valid/letter_stall | letter_item (letter_t)
//  result   | out       | result_valid/result_stall | result_item (result_t)
//  config   | in        | cfg_write                 | cfg_index, cfg_data
//
//  One letter transaction per cycle. A letter that completes a pair (or an
//  odd final letter, padded with x) looks up both letters in the square in
//  the same cycle and loads two results into the result register pair.
//  The result side drains one transaction per cycle unless stalled, so the
//  two-entry result register sets the pace: a pair every two letters runs
//  at full rate; an odd final letter gives two results for one letter, so a
//  pair formed right after it stalls until the second of those is leaving.
//  Reset (rst, synchronous) loads the alphabet square, encrypt mode and
//  empties the pairing and result state; no clearing pass follows.
//  A letter that would form a pair is stalled only while the result
//  registers cannot take a new pair this cycle.
// ----------------------------------------------------------------------------
`include "playfair_digraph_cipher_defines.svh"

module playfair_digraph_cipher
  import pf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // letter channel
  input  logic                 letter_valid,
  output logic                 letter_stall,
  input  letter_t              letter_item,
  // result channel
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result_item,
  // configuration
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROW_W-1:0]     cfg_data
);

  // configuration registers
  square_t sq;
  logic    cipher_mode;

  // pairing state
  logic [CODE_W-1:0] held_letter;
  logic              holding_first;

  // result registers: pending counts transactions still to deliver
  result_t     res_first;
  result_t     res_second;
  logic [1:0]  pending;
  logic [1:0]  pending_next;

  // handshake
  logic letter_acc;
  logic result_acc;
  logic needs_pair;
  logic room;
  logic load_pair;

  // pair datapath
  logic [CODE_W-1:0] mapped;
  logic [CODE_W-1:0] code_a;
  logic [CODE_W-1:0] code_b;
  logic              pair_last;
  loc_t              loc_a;
  loc_t              loc_b;
  logic [CODE_W-1:0] out_a;
  logic [CODE_W-1:0] out_b;
  logic              miss;

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  assign result_valid = (pending != 2'd0);
  assign result_item  = (pending == 2'd2) ? res_first : res_second;
  assign result_acc   = result_valid && !result_stall;

  // a pair is formed by a second letter or by an odd final letter
  assign needs_pair   = holding_first || letter_item.message_end;
  // room if empty, or the last result leaves this very cycle
  assign room         = (pending == 2'd0) || ((pending == 2'd1) && !result_stall);
  assign letter_stall = needs_pair && !room;
  assign letter_acc   = letter_valid && !letter_stall;
  assign load_pair    = letter_acc && needs_pair;

  // --------------------------------------------------------------------------
  // Pair formation and square lookup
  // --------------------------------------------------------------------------
  always_comb begin
    mapped = (letter_item.letter_code == CODE_J) ? CODE_I : letter_item.letter_code;
    if (holding_first) begin
      code_a    = held_letter;
      code_b    = mapped;
      pair_last = letter_item.message_end;
    end else begin
      // odd final letter padded with x
      code_a    = mapped;
      code_b    = CODE_X;
      pair_last = 1'b1;
    end
  end

  assign loc_a = locate(sq, code_a);
  assign loc_b = locate(sq, code_b);

  always_comb begin
    miss  = 1'b0;
    out_a = code_a;
    out_b = code_b;
    if (!loc_a.found || !loc_b.found) begin
      // letters pass through unchanged, flagged
      miss = 1'b1;
    end else if (loc_a.row == loc_b.row) begin
      // same row, equal letters included
      out_a = sq[loc_a.row][step_pos(loc_a.col, cipher_mode)];
      out_b = sq[loc_b.row][step_pos(loc_b.col, cipher_mode)];
    end else if (loc_a.col == loc_b.col) begin
      out_a = sq[step_pos(loc_a.row, cipher_mode)][loc_a.col];
      out_b = sq[step_pos(loc_b.row, cipher_mode)][loc_b.col];
    end else begin
      // rectangle: trade columns
      out_a = sq[loc_a.row][loc_b.col];
      out_b = sq[loc_b.row][loc_a.col];
    end
  end

  // --------------------------------------------------------------------------
  // Result count
  // --------------------------------------------------------------------------
  always_comb begin
    pending_next = pending;
    if (load_pair) begin
      pending_next = 2'd2;
    end else if (result_acc) begin
      pending_next = pending - 2'd1;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0]       <= row_t'(ROW0_RST);
      sq[1]       <= row_t'(ROW1_RST);
      sq[2]       <= row_t'(ROW2_RST);
      sq[3]       <= row_t'(ROW3_RST);
      sq[4]       <= row_t'(ROW4_RST);
      cipher_mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ROW0: sq[0]       <= row_t'(cfg_data);
        CFG_ROW1: sq[1]       <= row_t'(cfg_data);
        CFG_ROW2: sq[2]       <= row_t'(cfg_data);
        CFG_ROW3: sq[3]       <= row_t'(cfg_data);
        CFG_ROW4: sq[4]       <= row_t'(cfg_data);
        CFG_MODE: cipher_mode <= cfg_data[0];
        default: begin
          // unused indexes ignored
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holding_first <= 1'b0;
      held_letter   <= '0;
      pending       <= 2'd0;
    end else begin
      pending <= pending_next;
      if (letter_acc) begin
        if (holding_first) begin
          holding_first <= 1'b0;
        end else if (!letter_item.message_end) begin
          holding_first <= 1'b1;
          held_letter   <= mapped;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_pair) begin
      res_first.out_letter      <= out_a;
      res_first.second_of_pair  <= 1'b0;
      res_first.end_of_output   <= 1'b0;
      res_first.not_in_square   <= miss;
      res_second.out_letter     <= out_b;
      res_second.second_of_pair <= 1'b1;
      res_second.end_of_output  <= pair_last;
      res_second.not_in_square  <= miss;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `PF_ASSERT_NEXT(a_load_full, load_pair, pending == 2'd2,
    "pair load did not leave two results pending")
  `PF_ASSERT_NEXT(a_first_then_second, result_acc && (pending == 2'd2),
    result_valid && result_item.second_of_pair,
    "second result of a pair missing after the first")
  `PF_ASSERT_NEXT(a_pair_clears_hold, letter_acc && holding_first, !holding_first,
    "held letter kept after completing a pair")
  `PF_ASSERT_NOW(a_first_not_end, result_valid && !result_item.second_of_pair,
    !result_item.end_of_output,
    "end of output flagged on first result of a pair")
  `PF_ASSERT_NEXT(a_miss_flag_pair, result_acc && (pending == 2'd2),
    result_item.not_in_square == $past(result_item.not_in_square),
    "not-in-square flag differs within a pair")

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Playfair digraph cipher testbench
// Sends letter streams through the cipher under several key squares and both
// modes. A behavioural copy of the cipher predicts the result transactions;
// typed directed rows give their own. Both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import pf_pkg::*;

  localparam int HOLD_CYCLES = 300;       // long receiver hold-off
  localparam int TAIL_CYCLES = 4;         // settle time once nothing is due
  localparam int TIMEOUT_NS  = 4_000_000; // watchdog limit, in ns
  localparam int N_DIR       = 24;

  typedef logic [ROW_W-1:0] key_rows_t [SIDE];

  // directed row: letter, end flag, and an optional hand-typed pair
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
    logic              typed;
    logic [CODE_W-1:0] exp_a;
    logic [CODE_W-1:0] exp_b;
    logic              miss;
  } dir_row_t;

  // reset square: a b c d e / f g h i k / l m n o p / q r s t u / v w x y z
  localparam dir_row_t DIR_TABLE [N_DIR] = '{
    '{5'd0,  1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
    '{5'd1,  1'b0, 1'b1, 5'd1,  5'd2,  1'b0},  // same row: a b -> b c
    '{5'd0,  1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
    '{5'd5,  1'b0, 1'b1, 5'd5,  5'd11, 1'b0},  // same column: a f -> f l
    '{5'd0,  1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
    '{5'd6,  1'b0, 1'b1, 5'd1,  5'd5,  1'b0},  // rectangle: a g -> b f
    '{5'd4,  1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
    '{5'd0,  1'b0, 1'b1, 5'd0,  5'd1,  1'b0},  // column wrap: e a -> a b
    '{5'd25, 1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
    '{5'd4,  1'b0, 1'b1, 5'd4,  5'd10, 1'b0},  // row wrap: z e -> e k
    '{5'd9,  1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
    '{5'd10, 1'b0, 1'b1, 5'd10, 5'd5,  1'b0},  // j read as i: i k -> k f
    '{5'd2,  1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
    '{5'd2,  1'b0, 1'b1, 5'd3,  5'd3,  1'b0},  // equal pair: c c -> d d
    '{5'd25, 1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
    '{5'd0,  1'b0, 1'b1, 5'd21, 5'd4,  1'b0},  // corners: z a -> v e
    '{5'd0,  1'b1, 1'b1, 5'd2,  5'd21, 1'b0},  // odd end, x pad: a x -> c v
    '{5'd1,  1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
    '{5'd7,  1'b1, 1'b1, 5'd2,  5'd6,  1'b0},  // even end: b h -> c g
    '{5'd0,  1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
    '{5'd31, 1'b0, 1'b1, 5'd0,  5'd31, 1'b1},  // missing letter, passed through
    '{5'd31, 1'b1, 1'b1, 5'd31, 5'd23, 1'b1},  // odd end, missing letter
    '{5'd26, 1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
    '{5'd9,  1'b1, 1'b1, 5'd26, 5'd8,  1'b1}   // missing, j still read as i
  };

  logic                 clk;
  logic                 rst;
  logic                 letter_valid;
  logic                 letter_stall;
  letter_t              letter_item;
  logic                 result_valid;
  logic                 result_stall;
  result_t              result_item;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ROW_W-1:0]     cfg_data;

  // cipher copy: key square, mode and pairing state
  logic [ROW_W-1:0]  key_row [SIDE];
  logic              key_mode;
  logic [CODE_W-1:0] held_code;
  bit                held_valid;

  result_t cipher_due [$];   // predicted result transactions, oldest first
  int      mismatch_count;
  bit      hold_req;         // asks the receiver for one long hold-off
  bit      no_gap;           // sender runs flat out in this phase

  playfair_digraph_cipher u_top (
    .clk          (clk),
    .rst          (rst),
    .letter_valid (letter_valid),
    .letter_stall (letter_stall),
    .letter_item  (letter_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // --------------------------------------------------------------------------
  // cipher copy
  // --------------------------------------------------------------------------
  function automatic logic [CODE_W-1:0] key_cell(int r, int c);
    return key_row[r][CODE_W*c +: CODE_W];
  endfunction

  // first hit in row-major order, as duplicates resolve in the block
  function automatic bit key_find(logic [CODE_W-1:0] code, output int r, output int c);
    r = 0;
    c = 0;
    for (int i = 0; i < SIDE; i++) begin
      for (int k = 0; k < SIDE; k++) begin
        if (key_cell(i, k) == code) begin
          r = i;
          c = k;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic int key_shift(int v);
    return key_mode ? (v + SIDE - 1) % SIDE : (v + 1) % SIDE;
  endfunction

  function automatic void encode_pair(logic [CODE_W-1:0] a, logic [CODE_W-1:0] b,
                                      logic last, output result_t p0, output result_t p1);
    int ra, ca, rb, cb;
    logic [CODE_W-1:0] oa, ob;
    logic miss;
    oa   = a;
    ob   = b;
    miss = 1'b0;
    if (!key_find(a, ra, ca) || !key_find(b, rb, cb)) begin
      miss = 1'b1;
    end else if (ra == rb) begin
      oa = key_cell(ra, key_shift(ca));
      ob = key_cell(rb, key_shift(cb));
    end else if (ca == cb) begin
      oa = key_cell(key_shift(ra), ca);
      ob = key_cell(key_shift(rb), cb);
    end else begin
      oa = key_cell(ra, cb);
      ob = key_cell(rb, ca);
    end
    p0.out_letter     = oa;
    p0.second_of_pair = 1'b0;
    p0.end_of_output  = 1'b0;
    p0.not_in_square  = miss;
    p1.out_letter     = ob;
    p1.second_of_pair = 1'b1;
    p1.end_of_output  = last;
    p1.not_in_square  = miss;
  endfunction

  // returns 1 when the letter completes a pair (two results due)
  function automatic bit cipher_letter(letter_t it, output result_t p0, output result_t p1);
    logic [CODE_W-1:0] code;
    code = it.letter_code;
    p0   = '0;
    p1   = '0;
    if (code == CODE_J) code = CODE_I;
    if (held_valid) begin
      held_valid = 1'b0;
      encode_pair(held_code, code, it.message_end, p0, p1);
      return 1'b1;
    end
    if (it.message_end) begin
      encode_pair(code, CODE_X, 1'b1, p0, p1);
      return 1'b1;
    end
    held_code  = code;
    held_valid = 1'b1;
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (no_gap || r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // mostly letters that sit in the square, some plain codes, some noise
  function automatic logic [CODE_W-1:0] pick_letter();
    int r;
    r = $urandom_range(99, 0);
    if (r < 80) return key_cell($urandom_range(SIDE - 1, 0), $urandom_range(SIDE - 1, 0));
    if (r < 92) return CODE_W'($urandom_range(25, 0));
    return CODE_W'($urandom_range(31, 0));
  endfunction

  // random arrangement of the 25 letters without j
  function automatic void shuffle_key(output key_rows_t rows);
    logic [CODE_W-1:0] pool [SIDE*SIDE];
    logic [CODE_W-1:0] t;
    int n, j;
    n = 0;
    for (int k = 0; k < 26; k++) begin
      if (CODE_W'(k) != CODE_J) begin
        pool[n] = CODE_W'(k);
        n++;
      end
    end
    for (int k = SIDE*SIDE - 1; k > 0; k--) begin
      j       = $urandom_range(k, 0);
      t       = pool[k];
      pool[k] = pool[j];
      pool[j] = t;
    end
    for (int k = 0; k < SIDE; k++) rows[k] = '0;
    for (int k = 0; k < SIDE*SIDE; k++) rows[k/SIDE][CODE_W*(k%SIDE) +: CODE_W] = pool[k];
  endfunction

  // one letter transaction; typed rows replace the predicted pair
  task automatic send_letter(input letter_t it, input int gap, input bit typed,
                             input result_t t0, input result_t t1);
    result_t p0, p1;
    bit emits;
    if (gap > 0) begin
      letter_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    letter_valid <= 1'b1;
    letter_item  <= it;
    do @(posedge clk); while (letter_stall);
    emits = cipher_letter(it, p0, p1);
    if (typed) begin
      p0 = t0;
      p1 = t1;
    end
    if (emits) begin
      cipher_due.push_back(p0);
      cipher_due.push_back(p1);
    end
  endtask

  // sender stops until every due result has come back
  task automatic wait_idle();
    letter_valid <= 1'b0;
    while (cipher_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // writes every register back to back; only called with the block idle
  task automatic load_key(input key_rows_t rows, input logic mode);
    for (int i = CFG_ROW0; i <= CFG_ROW4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= rows[i];
      @(posedge clk);
      key_row[i] = rows[i];
    end
    cfg_write <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data  <= ROW_W'(mode);
    @(posedge clk);
    key_mode = mode;
    cfg_write <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // receiver: alternating open and stalled stretches, plus one long hold
  // --------------------------------------------------------------------------
  initial begin : receiver
    bit stall_now;
    int n;
    stall_now = 1'b0;
    result_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        // block fills up and must stall the letter side
        hold_req = 1'b0;
        stall_now = 1'b1;
        n = HOLD_CYCLES;
      end else begin
        stall_now = !stall_now;
        if (stall_now) n = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 20)
                                                       : $urandom_range(3, 1);
        else n = $urandom_range(30, 1);
      end
      result_stall <= stall_now;
      repeat (n) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // result check against the oldest due transaction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (cipher_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with none due: letter=%0d second=%0b end=%0b miss=%0b",
                   $realtime, result_item.out_letter, result_item.second_of_pair,
                   result_item.end_of_output, result_item.not_in_square);
      end else begin
        want = cipher_due.pop_front();
        if (result_item.out_letter     !== want.out_letter     ||
            result_item.second_of_pair !== want.second_of_pair ||
            result_item.end_of_output  !== want.end_of_output  ||
            result_item.not_in_square  !== want.not_in_square) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"%0t: result mismatch: exp letter=%0d second=%0b end=%0b miss=%0b,",
                      " got letter=%0d second=%0b end=%0b miss=%0b"},
                     $realtime, want.out_letter, want.second_of_pair,
                     want.end_of_output, want.not_in_square,
                     result_item.out_letter, result_item.second_of_pair,
                     result_item.end_of_output, result_item.not_in_square);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    letter_t   it;
    result_t   t0, t1;
    key_rows_t rows;
    logic      mode;
    int        count, msg_left;

    mismatch_count = 0;
    hold_req       = 1'b0;
    no_gap         = 1'b0;
    key_row[0]     = ROW0_RST;
    key_row[1]     = ROW1_RST;
    key_row[2]     = ROW2_RST;
    key_row[3]     = ROW3_RST;
    key_row[4]     = ROW4_RST;
    key_mode       = 1'b0;
    held_code      = '0;
    held_valid     = 1'b0;

    rst          <= 1'b1;
    letter_valid <= 1'b0;
    letter_item  <= '0;
    cfg_write    <= 1'b0;
    cfg_index    <= CFG_ROW0;
    cfg_data     <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed rows on the reset square, encrypt
    for (int k = 0; k < N_DIR; k++) begin
      it.letter_code    = DIR_TABLE[k].code;
      it.message_end    = DIR_TABLE[k].last;
      t0.out_letter     = DIR_TABLE[k].exp_a;
      t0.second_of_pair = 1'b0;
      t0.end_of_output  = 1'b0;
      t0.not_in_square  = DIR_TABLE[k].miss;
      t1.out_letter     = DIR_TABLE[k].exp_b;
      t1.second_of_pair = 1'b1;
      t1.end_of_output  = DIR_TABLE[k].last;
      t1.not_in_square  = DIR_TABLE[k].miss;
      send_letter(it, pick_gap(), DIR_TABLE[k].typed, t0, t1);
    end
    wait_idle();

    // random phases, each under its own square and mode
    for (int ph = 0; ph < 8; ph++) begin
      no_gap = (ph == 4);
      case (ph)
        0: begin
          // all-zero square: only letter a is found
          for (int r = 0; r < SIDE; r++) rows[r] = '0;
          mode  = 1'b0;
          count = 30;
        end
        1: begin
          // every entry 31
          for (int r = 0; r < SIDE; r++) rows[r] = '1;
          mode  = 1'b1;
          count = 30;
        end
        2: begin
          rows[0] = ROW0_RST;
          rows[1] = ROW1_RST;
          rows[2] = ROW2_RST;
          rows[3] = ROW3_RST;
          rows[4] = ROW4_RST;
          mode    = 1'b1;
          count   = 100;
        end
        7: begin
          // raw codes: duplicates and codes above z
          for (int r = 0; r < SIDE; r++) rows[r] = ROW_W'($urandom());
          mode  = 1'($urandom_range(1, 0));
          count = 100;
        end
        default: begin
          shuffle_key(rows);
          mode  = ph[0];
          count = 140;
        end
      endcase
      load_key(rows, mode);
      if (ph == 3) hold_req = 1'b1;

      msg_left = 0;
      for (int i = 0; i < count; i++) begin
        if (msg_left == 0) msg_left = $urandom_range(12, 1);
        msg_left--;
        it.letter_code = pick_letter();
        it.message_end = (msg_left == 0) || (i == count - 1);
        send_letter(it, pick_gap(), 1'b0, '0, '0);
      end
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
